### src/atls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atls_pkg
// Shared widths, limits, register indexes and pipeline payload types of the
// atlas tile scatter unit.
// ----------------------------------------------------------------------------
package atls_pkg;

    localparam int POS_W      = 10;
    localparam int ARGB_W     = 32;
    localparam int ORIGIN_W   = 12;
    localparam int SIDE_W     = 9;
    localparam int TOTAL_W    = 17;
    localparam int SLICE_W    = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_TILE_SIDE = 256;
    localparam int MAX_TILES     = 65536;

    localparam logic [ARGB_W-1:0] FILL_KEY = 32'h0000_FF00;

    // atlas coordinate: origin plus position
    localparam int AX_W       = 13;
    localparam int REM_W      = SIDE_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (AX_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam int IDX_W   = 23;
    localparam int INNER_W = 18;
    localparam int TILE_W  = 16;
    localparam int OFS_W   = 18;

    localparam int IN_TDATA_W  = ((2 * POS_W + ARGB_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((TILE_W + OFS_W + ARGB_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 4'd0,
        REG_ORIGIN_Y   = 4'd1,
        REG_SIDE_X     = 4'd2,
        REG_SIDE_Y     = 4'd3,
        REG_TILES_ROW  = 4'd4,
        REG_TILE_TOTAL = 4'd5,
        REG_SLICE_COLS = 4'd6,
        REG_SLICE_ROWS = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic              ok;
        logic [ARGB_W-1:0] argb;
    } side_t;

    typedef struct packed {
        logic [AX_W-1:0] num_x;
        logic [AX_W-1:0] num_y;
        side_t           side;
    } div_req_t;

    typedef struct packed {
        logic [AX_W-1:0]  quo_x;
        logic [REM_W-1:0] rem_x;
        logic [AX_W-1:0]  quo_y;
        logic [REM_W-1:0] rem_y;
        side_t            side;
    } div_rsp_t;

endpackage

### src/atls_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atls_div_pipe
// Two-lane pipelined restoring divider: atlas x and y by the tile sides,
// a few quotient bits per stage, side data carried along.
// ----------------------------------------------------------------------------
module atls_div_pipe
    import atls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  div_req_t         in_req,
    input  logic [REM_W-1:0] den_x,
    input  logic [REM_W-1:0] den_y,
    output logic             out_valid,
    input  logic             out_ready,
    output div_rsp_t         out_rsp
);

    function automatic logic [REM_W+AX_W-1:0] div_run(
        input logic [REM_W-1:0] r_in,
        input logic [AX_W-1:0]  s_in,
        input logic [REM_W-1:0] den,
        input int               nsteps
    );
        logic [REM_W:0]   t;
        logic [REM_W-1:0] r;
        logic [AX_W-1:0]  s;
        r = r_in;
        s = s_in;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k < nsteps)
            begin
                t = {r, s[AX_W-1]};
                s = {s[AX_W-2:0], 1'b0};
                if (t >= {1'b0, den})
                begin
                    t    = t - {1'b0, den};
                    s[0] = 1'b1;
                end
                r = t[REM_W-1:0];
            end
        end
        return {r, s};
    endfunction

    logic             vld_reg [DIV_STAGES];
    logic             rdy     [DIV_STAGES+1];
    logic [REM_W-1:0] rx_reg  [DIV_STAGES];
    logic [REM_W-1:0] ry_reg  [DIV_STAGES];
    logic [AX_W-1:0]  sx_reg  [DIV_STAGES];
    logic [AX_W-1:0]  sy_reg  [DIV_STAGES];
    side_t            side_reg[DIV_STAGES];

    assign rdy[DIV_STAGES] = out_ready;
    assign in_ready        = rdy[0];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int NS = (AX_W - s * DIV_STEPS) < DIV_STEPS ?
                            (AX_W - s * DIV_STEPS) : DIV_STEPS;

        logic                    prev_valid;
        logic [REM_W-1:0]        rx_in;
        logic [REM_W-1:0]        ry_in;
        logic [AX_W-1:0]         sx_in;
        logic [AX_W-1:0]         sy_in;
        side_t                   side_in;
        logic [REM_W+AX_W-1:0]   x_next;
        logic [REM_W+AX_W-1:0]   y_next;

        if (s == 0)
        begin : g_first
            assign prev_valid = in_valid;
            assign rx_in      = '0;
            assign ry_in      = '0;
            assign sx_in      = in_req.num_x;
            assign sy_in      = in_req.num_y;
            assign side_in    = in_req.side;
        end
        else
        begin : g_next
            assign prev_valid = vld_reg[s-1];
            assign rx_in      = rx_reg[s-1];
            assign ry_in      = ry_reg[s-1];
            assign sx_in      = sx_reg[s-1];
            assign sy_in      = sy_reg[s-1];
            assign side_in    = side_reg[s-1];
        end

        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        always_comb
        begin
            x_next = div_run(rx_in, sx_in, den_x, NS);
            y_next = div_run(ry_in, sy_in, den_y, NS);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                vld_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && prev_valid)
            begin
                rx_reg[s]   <= x_next[REM_W+AX_W-1:AX_W];
                sx_reg[s]   <= x_next[AX_W-1:0];
                ry_reg[s]   <= y_next[REM_W+AX_W-1:AX_W];
                sy_reg[s]   <= y_next[AX_W-1:0];
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid     = vld_reg[DIV_STAGES-1];
    assign out_rsp.quo_x = sx_reg[DIV_STAGES-1];
    assign out_rsp.rem_x = rx_reg[DIV_STAGES-1];
    assign out_rsp.quo_y = sy_reg[DIV_STAGES-1];
    assign out_rsp.rem_y = ry_reg[DIV_STAGES-1];
    assign out_rsp.side  = side_reg[DIV_STAGES-1];

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("divider refuses requests while its last stage is empty");

endmodule

### src/atlas_tile_scatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlas_tile_scatter_unit
// Places source slice pixels into a tiled atlas: tile index, byte offset and
// keyed texel value for each pixel.
//
//   channel  dir  handshake                  payload
//   s_axis   in   s_axis_tvalid/tready       row, col, argb
//   m_axis   out  m_axis_tvalid/tready       tuser: write_valid; tdata: result
//   cfg      in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One request per cycle sustained unless m_axis_tready holds the output; the
// stages are input stage, divider stages, multiply stage and output stage, the
// divider a restoring one at up to DIV_STEPS quotient bits per stage.
// Reset clears all stage valid bits and all configuration registers to zero.
// A stalled output holds every stage that is full; empty stages keep filling.
// ----------------------------------------------------------------------------
module atlas_tile_scatter_unit
    import atls_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pixel_row, pixel_col, pixel_argb
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // tile_number, byte_offset, texel_argb
    output logic                   m_axis_tuser,   // write_valid
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [SIDE_W:0]  SIDE_LIMIT = (SIDE_W + 1)'(MAX_TILE_SIDE);
    localparam logic [IDX_W-1:0] TILE_LIMIT = IDX_W'(MAX_TILES);

    logic [ORIGIN_W-1:0] origin_x_reg;
    logic [ORIGIN_W-1:0] origin_y_reg;
    logic [SIDE_W-1:0]   side_x_reg;
    logic [SIDE_W-1:0]   side_y_reg;
    logic [SIDE_W-1:0]   tiles_row_reg;
    logic [TOTAL_W-1:0]  tile_total_reg;
    logic [SLICE_W-1:0]  slice_cols_reg;
    logic [SLICE_W-1:0]  slice_rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            side_x_reg     <= '0;
            side_y_reg     <= '0;
            tiles_row_reg  <= '0;
            tile_total_reg <= '0;
            slice_cols_reg <= '0;
            slice_rows_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg   <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_data[ORIGIN_W-1:0];
                REG_SIDE_X:     side_x_reg     <= cfg_data[SIDE_W-1:0];
                REG_SIDE_Y:     side_y_reg     <= cfg_data[SIDE_W-1:0];
                REG_TILES_ROW:  tiles_row_reg  <= cfg_data[SIDE_W-1:0];
                REG_TILE_TOTAL: tile_total_reg <= cfg_data[TOTAL_W-1:0];
                REG_SLICE_COLS: slice_cols_reg <= cfg_data[SLICE_W-1:0];
                REG_SLICE_ROWS: slice_rows_reg <= cfg_data[SLICE_W-1:0];
                default:        ;
            endcase
        end
    end

    // input stage: atlas position, range checks, color key
    logic [POS_W-1:0]  in_row;
    logic [POS_W-1:0]  in_col;
    logic [ARGB_W-1:0] in_argb;
    logic              in_ok;

    assign in_row  = s_axis_tdata[POS_W-1:0];
    assign in_col  = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_argb = s_axis_tdata[2*POS_W+ARGB_W-1:2*POS_W];

    assign in_ok = (side_x_reg != '0) && (side_y_reg != '0) && (tiles_row_reg != '0) &&
                   ({1'b0, side_x_reg} <= SIDE_LIMIT) &&
                   ({1'b0, side_y_reg} <= SIDE_LIMIT) &&
                   (SLICE_W'(in_row) < slice_rows_reg) &&
                   (SLICE_W'(in_col) < slice_cols_reg);

    logic     a_vld_reg;
    logic     a_rdy;
    div_req_t a_req_reg;
    div_req_t a_req_next;
    logic     div_in_ready;

    always_comb
    begin
        a_req_next.num_x     = AX_W'(origin_x_reg) + AX_W'(in_col);
        a_req_next.num_y     = AX_W'(origin_y_reg) + AX_W'(in_row);
        a_req_next.side.ok   = in_ok;
        a_req_next.side.argb = (in_argb == FILL_KEY) ? '0 : in_argb;
    end

    assign a_rdy         = !a_vld_reg || div_in_ready;
    assign s_axis_tready = a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (a_rdy)
        begin
            a_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && s_axis_tvalid)
        begin
            a_req_reg <= a_req_next;
        end
    end

    // divider stages
    logic     div_out_valid;
    div_rsp_t div_rsp;
    logic     m_rdy;

    atls_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_vld_reg),
        .in_ready  (div_in_ready),
        .in_req    (a_req_reg),
        .den_x     (side_x_reg),
        .den_y     (side_y_reg),
        .out_valid (div_out_valid),
        .out_ready (m_rdy),
        .out_rsp   (div_rsp)
    );

    // multiply stage
    logic               m_vld_reg;
    logic [IDX_W-1:0]   m_prod_y_reg;
    logic [INNER_W-1:0] m_prod_r_reg;
    logic [AX_W-1:0]    m_quo_x_reg;
    logic [REM_W-1:0]   m_rem_x_reg;
    side_t              m_side_reg;
    logic               o_rdy;

    assign m_rdy = !m_vld_reg || o_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (m_rdy)
        begin
            m_vld_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_rdy && div_out_valid)
        begin
            m_prod_y_reg <= IDX_W'(div_rsp.quo_y) * IDX_W'(tiles_row_reg);
            m_prod_r_reg <= INNER_W'(div_rsp.rem_y) * INNER_W'(side_x_reg);
            m_quo_x_reg  <= div_rsp.quo_x;
            m_rem_x_reg  <= div_rsp.rem_x;
            m_side_reg   <= div_rsp.side;
        end
    end

    // output stage
    logic [IDX_W-1:0]   o_index;
    logic [INNER_W-1:0] o_inner;
    logic               o_hit;

    logic               o_vld_reg;
    logic               o_wv_reg;
    logic [TILE_W-1:0]  o_tile_reg;
    logic [OFS_W-1:0]   o_ofs_reg;
    logic [ARGB_W-1:0]  o_argb_reg;

    assign o_index = m_prod_y_reg + IDX_W'(m_quo_x_reg);
    assign o_inner = m_prod_r_reg + INNER_W'(m_rem_x_reg);
    assign o_hit   = m_side_reg.ok && (o_index < IDX_W'(tile_total_reg)) &&
                     (o_index < TILE_LIMIT);
    assign o_rdy   = !o_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (o_rdy)
        begin
            o_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_rdy && m_vld_reg)
        begin
            o_wv_reg   <= o_hit;
            o_tile_reg <= o_hit ? o_index[TILE_W-1:0] : '0;
            o_ofs_reg  <= o_hit ? {o_inner[OFS_W-3:0], 2'b00} : '0;
            o_argb_reg <= o_hit ? m_side_reg.argb : '0;
        end
    end

    assign m_axis_tvalid = o_vld_reg;
    assign m_axis_tuser  = o_wv_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - TILE_W - OFS_W - ARGB_W)'(0),
                            o_argb_reg, o_ofs_reg, o_tile_reg};

    a_drop_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("dropped request carries nonzero result fields");

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without output back-pressure");

    a_output_fed: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(m_vld_reg))
        else $error("output became valid without a request in the multiply stage");

endmodule

### dv/tb_atlas_tile_scatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atlas_tile_scatter_unit
// Stream-level check of the atlas tile scatter unit. Pixels are sent on the
// slave stream under random idling on both sides. Each accepted pixel is
// placed by a behavioral placement function using the current register
// image, and every write request leaving the master stream is compared with
// the oldest pending placement. Directed tests cover the reset state, the
// fill key, slice and tile limits and disabled configurations; random
// slices follow, each with its own register settings.
// ----------------------------------------------------------------------------
module tb_atlas_tile_scatter_unit;
    import atls_pkg::*;

    localparam int LATENCY       = 3 + DIV_STAGES;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_SLICES = 20;
    localparam int SLICE_PIXELS  = 55;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;

    typedef struct {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [ARGB_W-1:0] argb;
    } pixel_t;

    typedef struct {
        logic              write_valid;
        logic [TILE_W-1:0] tile_number;
        logic [OFS_W-1:0]  byte_offset;
        logic [ARGB_W-1:0] texel_argb;
    } placement_t;

    typedef struct {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [SIDE_W-1:0]   side_x;
        logic [SIDE_W-1:0]   side_y;
        logic [SIDE_W-1:0]   tiles_row;
        logic [TOTAL_W-1:0]  tile_total;
        logic [SLICE_W-1:0]  slice_cols;
        logic [SLICE_W-1:0]  slice_rows;
    } atlas_cfg_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    atlas_cfg_t atlas_cfg;
    placement_t pending_writes[$];
    placement_t want_write;
    placement_t got_write;
    int         mismatches   = 0;
    int         stall_cycles = 0;
    bit         steady       = 1'b0;

    atlas_tile_scatter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic placement_t place_pixel(pixel_t px, atlas_cfg_t c);
        placement_t  w;
        int unsigned ax;
        int unsigned ay;
        int unsigned tindex;
        int unsigned offs;
        w = '{write_valid: 1'b0, tile_number: '0, byte_offset: '0, texel_argb: '0};
        if (c.side_x == 0 || c.side_y == 0 || c.tiles_row == 0 ||
            c.side_x > MAX_TILE_SIDE || c.side_y > MAX_TILE_SIDE ||
            px.row >= c.slice_rows || px.col >= c.slice_cols)
            return w;
        ax     = c.origin_x + px.col;
        ay     = c.origin_y + px.row;
        tindex = (ay / c.side_y) * c.tiles_row + ax / c.side_x;
        if (tindex >= c.tile_total || tindex >= MAX_TILES)
            return w;
        offs = ((ay % c.side_y) * c.side_x + ax % c.side_x) * 4;
        w.write_valid = 1'b1;
        w.tile_number = tindex[TILE_W-1:0];
        w.byte_offset = offs[OFS_W-1:0];
        w.texel_argb  = (px.argb == FILL_KEY) ? '0 : px.argb;
        return w;
    endfunction

    function automatic pixel_t make_pixel(int unsigned row, int unsigned col,
                                          logic [ARGB_W-1:0] argb);
        pixel_t px;
        px.row  = row[POS_W-1:0];
        px.col  = col[POS_W-1:0];
        px.argb = argb;
        return px;
    endfunction

    function automatic bit idle_roll();
        return !steady && ($urandom_range(0, 99) < 32);
    endfunction

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    always @(negedge clk)
        m_axis_tready <= !idle_roll();

    task automatic send_pixel(pixel_t px);
        @(negedge clk);
        while (idle_roll())
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_TDATA_W'({px.argb, px.col, px.row});
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_writes.push_back(place_pixel(px, atlas_cfg));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ORIGIN_X:   atlas_cfg.origin_x   = value[ORIGIN_W-1:0];
            REG_ORIGIN_Y:   atlas_cfg.origin_y   = value[ORIGIN_W-1:0];
            REG_SIDE_X:     atlas_cfg.side_x     = value[SIDE_W-1:0];
            REG_SIDE_Y:     atlas_cfg.side_y     = value[SIDE_W-1:0];
            REG_TILES_ROW:  atlas_cfg.tiles_row  = value[SIDE_W-1:0];
            REG_TILE_TOTAL: atlas_cfg.tile_total = value[TOTAL_W-1:0];
            REG_SLICE_COLS: atlas_cfg.slice_cols = value[SLICE_W-1:0];
            REG_SLICE_ROWS: atlas_cfg.slice_rows = value[SLICE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_atlas(int unsigned ox, int unsigned oy, int unsigned sx,
                                 int unsigned sy, int unsigned tr, int unsigned total,
                                 int unsigned cols, int unsigned rows);
        write_reg(REG_ORIGIN_X,   ox[CFG_DATA_W-1:0]);
        write_reg(REG_ORIGIN_Y,   oy[CFG_DATA_W-1:0]);
        write_reg(REG_SIDE_X,     sx[CFG_DATA_W-1:0]);
        write_reg(REG_SIDE_Y,     sy[CFG_DATA_W-1:0]);
        write_reg(REG_TILES_ROW,  tr[CFG_DATA_W-1:0]);
        write_reg(REG_TILE_TOTAL, total[CFG_DATA_W-1:0]);
        write_reg(REG_SLICE_COLS, cols[CFG_DATA_W-1:0]);
        write_reg(REG_SLICE_ROWS, rows[CFG_DATA_W-1:0]);
    endtask

    // all registers still zero: every pixel is dropped
    task automatic test_reset_config();
        send_pixel(make_pixel(0, 0, 32'h0000_0000));
        send_pixel(make_pixel(1023, 1023, 32'hFFFF_FFFF));
        send_pixel(make_pixel(512, 1, FILL_KEY));
    endtask

    task automatic test_fill_key_and_extremes();
        wait_idle();
        program_atlas(0, 0, 16, 16, 8, 64, 128, 128);
        send_pixel(make_pixel(0, 0, FILL_KEY));
        send_pixel(make_pixel(0, 0, FILL_KEY ^ 32'h1));
        send_pixel(make_pixel(127, 127, 32'hFFFF_FFFF));
        send_pixel(make_pixel(128, 0, 32'h1234_5678));
        send_pixel(make_pixel(0, 128, 32'h1234_5678));
        send_pixel(make_pixel(1023, 1023, 32'hFFFF_FFFF));
        send_pixel(make_pixel(5, 37, 32'hA5A5_A5A5));
        wait_idle();
        write_reg(REG_TILE_TOTAL, 17'd63);
        send_pixel(make_pixel(127, 127, 32'h5A5A_5A5A));
        send_pixel(make_pixel(126, 112, 32'h0F0F_0F0F));
        send_pixel(make_pixel(0, 0, 32'hF0F0_F0F0));
        wait_idle();
        program_atlas(4095, 4095, 256, 256, 256, 131071, 1024, 1024);
        send_pixel(make_pixel(0, 0, FILL_KEY));
        send_pixel(make_pixel(1023, 1023, 32'h8000_0001));
    endtask

    task automatic test_tile_limits();
        wait_idle();
        program_atlas(0, 0, 1, 1, 256, 131071, 1024, 1024);
        send_pixel(make_pixel(0, 5, 32'h0102_0304));
        send_pixel(make_pixel(255, 255, 32'hCAFE_0001));
        send_pixel(make_pixel(256, 0, 32'hCAFE_0002));
        wait_idle();
        write_reg(REG_TILE_TOTAL, 17'd65535);
        send_pixel(make_pixel(255, 255, 32'hCAFE_0003));
    endtask

    task automatic test_disabled_configs();
        wait_idle();
        program_atlas(7, 3, 300, 2, 4, 1000, 64, 64);
        send_pixel(make_pixel(1, 1, 32'h1111_1111));
        wait_idle();
        write_reg(REG_SIDE_X, 17'd2);
        write_reg(REG_SIDE_Y, 17'd511);
        send_pixel(make_pixel(1, 1, 32'h2222_2222));
        wait_idle();
        write_reg(REG_SIDE_Y, 17'd2);
        write_reg(REG_TILES_ROW, 17'd0);
        send_pixel(make_pixel(1, 1, 32'h3333_3333));
        wait_idle();
        write_reg(REG_TILES_ROW, 17'd4);
        write_reg(REG_UNMAPPED, 17'h1FFFF);
        send_pixel(make_pixel(1, 1, 32'h4444_4444));
    endtask

    task automatic test_random_slices();
        int unsigned ox, oy, sx, sy, tr, total, cols, rows;
        int unsigned row, col;
        logic [ARGB_W-1:0] argb;
        for (int s = 0; s < RANDOM_SLICES; s++)
        begin
            wait_idle();
            ox = ($urandom_range(0, 1)) ? $urandom_range(0, 63) : pick(0, 4095);
            oy = ($urandom_range(0, 1)) ? $urandom_range(0, 63) : pick(0, 4095);
            case ($urandom_range(0, 19))
                0:       sx = 0;
                1:       sx = $urandom_range(257, 511);
                2:       sx = 256;
                3:       sx = 1;
                4, 5, 6: sx = $urandom_range(33, 255);
                default: sx = $urandom_range(2, 32);
            endcase
            case ($urandom_range(0, 19))
                0:       sy = 0;
                1:       sy = $urandom_range(257, 511);
                2:       sy = 256;
                3:       sy = 1;
                4, 5, 6: sy = $urandom_range(33, 255);
                default: sy = $urandom_range(2, 32);
            endcase
            case ($urandom_range(0, 19))
                0:       tr = 0;
                1:       tr = $urandom_range(257, 511);
                default: tr = pick(1, 256);
            endcase
            case ($urandom_range(0, 9))
                0:       total = 0;
                1, 2:    total = $urandom_range(0, 131071);
                3:       total = $urandom_range(1, 2048);
                4:       total = 65536;
                default: total = 131071;
            endcase
            case ($urandom_range(0, 19))
                0:       cols = 0;
                1:       cols = $urandom_range(1025, 2047);
                default: cols = pick(1, 1024);
            endcase
            case ($urandom_range(0, 19))
                0:       rows = 0;
                1:       rows = $urandom_range(1025, 2047);
                default: rows = pick(1, 1024);
            endcase
            program_atlas(ox, oy, sx, sy, tr, total, cols, rows);
            steady = (s == 6);
            for (int n = 0; n < SLICE_PIXELS; n++)
            begin
                if (rows != 0 && $urandom_range(0, 9) < 8)
                    row = pick(0, (rows > 1024) ? 1023 : rows - 1);
                else
                    row = $urandom_range(0, 1023);
                if (cols != 0 && $urandom_range(0, 9) < 8)
                    col = pick(0, (cols > 1024) ? 1023 : cols - 1);
                else
                    col = $urandom_range(0, 1023);
                argb = ($urandom_range(0, 9) == 0) ? FILL_KEY : $urandom;
                send_pixel(make_pixel(row, col, argb));
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_write.write_valid = m_axis_tuser;
            got_write.tile_number = m_axis_tdata[TILE_W-1:0];
            got_write.byte_offset = m_axis_tdata[TILE_W +: OFS_W];
            got_write.texel_argb  = m_axis_tdata[TILE_W + OFS_W +: ARGB_W];
            if (pending_writes.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: write request with none pending: valid=%b tile=%0d ofs=%0d argb=%h",
                             $realtime, got_write.write_valid, got_write.tile_number,
                             got_write.byte_offset, got_write.texel_argb);
                mismatches++;
            end
            else
            begin
                want_write = pending_writes.pop_front();
                if (got_write.write_valid !== want_write.write_valid ||
                    got_write.tile_number !== want_write.tile_number ||
                    got_write.byte_offset !== want_write.byte_offset ||
                    got_write.texel_argb  !== want_write.texel_argb)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: mismatch exp valid=%b tile=%0d ofs=%0d argb=%h, got valid=%b tile=%0d ofs=%0d argb=%h",
                                 $realtime, want_write.write_valid, want_write.tile_number,
                                 want_write.byte_offset, want_write.texel_argb,
                                 got_write.write_valid, got_write.tile_number,
                                 got_write.byte_offset, got_write.texel_argb);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        atlas_cfg = '{origin_x: '0, origin_y: '0, side_x: '0, side_y: '0, tiles_row: '0,
                      tile_total: '0, slice_cols: '0, slice_rows: '0};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_config();
        test_fill_key_and_extremes();
        test_tile_limits();
        test_disabled_configs();
        test_random_slices();
        wait_idle();
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
